// File: rtl/stcm_pkg.sv
// stcm_pkg: shared widths, register indexes and drawing codes of the sample trace column mapper
// no dependencies; imported by stcm_divider and sample_trace_column_mapper

package stcm_pkg;

   localparam int MAX_SCALE  = 64;
   localparam int COORD_BITS = 10;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 24;
   localparam int XPOS_W   = COORD_BITS + 1;
   localparam int SUM_W    = 23;
   localparam int GROUP_W  = 7;
   localparam int CNT_W    = $clog2(SUM_W + 1);
   localparam int SCALE_W  = 8;
   localparam int MODE_W   = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int RSP_DATA_W  = 40;

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] REG_X_SCALE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_OFFSET    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PLOT_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PLOT_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_X      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_Y      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DRAW_MODE   = 3'd7;

   // draw modes and result kinds share the same codes
   localparam logic [MODE_W-1:0] KIND_PIXEL  = 2'd0;
   localparam logic [MODE_W-1:0] KIND_LINE   = 2'd1;
   localparam logic [MODE_W-1:0] KIND_AREA   = 2'd2;
   localparam logic [MODE_W-1:0] KIND_UNUSED = 2'd3;

   // handshake between the sequencer and the divider
   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] dividend;
      logic [GROUP_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/stcm_divider.sv
// stcm_divider: restoring signed divider, one quotient bit per cycle, truncates toward zero
// depends on stcm_pkg

module stcm_divider import stcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [GROUP_W-1:0]  rem_ff, rem_in;
   logic [GROUP_W-1:0]  dsr_ff, dsr_in;
   logic                neg_ff, neg_in;

   logic [GROUP_W:0]    shifted;
   logic [GROUP_W:0]    diff;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         neg_in  = div_req.dividend[SUM_W-1];
         quo_in  = div_req.dividend[SUM_W-1] ? SUM_W'(-div_req.dividend)
                                             : SUM_W'(div_req.dividend);
      end else if (busy_ff) begin
         rem_in = fits ? diff[GROUP_W-1:0] : shifted[GROUP_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

endmodule

// File: rtl/sample_trace_column_mapper.sv
// sample_trace_column_mapper: maps raw samples onto chart trace columns (pixel, line or area)
// depends on stcm_pkg and stcm_divider
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tdata[15:0] sample, tlast last_sample
//  rsp      out        rsp_tvalid/tready    tdata x_pos,y_from,y_to,clipped,trace_clipped;
//                                           tuser kind, tlast run_last
//  csr      in         csr_valid/ready      csr_index register, csr_data value
//
//  one sample at a time: accept, decode, multiply, scale/clip, then one column per cycle while
//  the rsp channel is not stalled; an averaging sample that leaves its group open goes from
//  decode straight to finish and emits no column, and one that closes its group first waits
//  in the divide state for the bit-serial divider
//  reset is synchronous, active high; it restores register defaults and clears the trace
//  a stalled rsp channel holds the column sequencer; req_tready is low until the sample is done

module sample_trace_column_mapper import stcm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // input samples
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [SAMPLE_W-1:0]       req_tdata,   // [15:0] sample
   input  logic                      req_tlast,   // last_sample
   // drawing results
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_W-1:0]     rsp_tdata,   // x_pos, y_from, y_to, clipped, trace_clipped
   output logic [MODE_W-1:0]         rsp_tuser,   // kind
   output logic                      rsp_tlast,   // run_last
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_SCALE  = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   localparam int PROD_W = GAIN_W + SAMPLE_W + 2;

   // screen y of a height above the bottom line, saturating at the top of the screen
   function automatic logic [COORD_BITS-1:0] screen_y(input logic [COORD_BITS-1:0] by,
                                                      input logic [COORD_BITS-1:0] h);
      screen_y = (h > by) ? '0 : by - h;
   endfunction

   // configuration registers
   logic signed [SCALE_W-1:0]  x_scale_ff, x_scale_in;
   logic [GAIN_W-1:0]          y_gain_ff, y_gain_in;
   logic signed [SAMPLE_W-1:0] y_offset_ff, y_offset_in;
   logic [COORD_BITS-1:0]      plot_width_ff, plot_width_in;
   logic [COORD_BITS-1:0]      plot_height_ff, plot_height_in;
   logic [COORD_BITS-1:0]      base_x_ff, base_x_in;
   logic [COORD_BITS-1:0]      base_y_ff, base_y_in;
   logic [MODE_W-1:0]          draw_mode_ff, draw_mode_in;

   // trace state
   logic [XPOS_W-1:0]          col_ff, col_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [GROUP_W-1:0]         grp_ff, grp_in;
   logic [COORD_BITS-1:0]      prev_ff, prev_in;
   logic                       first_ff, first_in;
   logic                       sticky_ff, sticky_in;

   // per-sample work registers
   logic [2:0]                 state_ff, state_in;
   logic signed [SAMPLE_W-1:0] smp_ff, smp_in;
   logic                       last_ff, last_in;
   logic signed [SAMPLE_W-1:0] val_ff, val_in;
   logic [GROUP_W-1:0]         rep_ff, rep_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [COORD_BITS-1:0]      h_ff, h_in;
   logic                       hclip_ff, hclip_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [MODE_W-1:0]          rsp_kind_ff, rsp_kind_in;
   logic                       rsp_last_ff, rsp_last_in;

   div_req_type                div_req;
   div_rsp_type                div_rsp;

   // scale decode
   logic [SCALE_W-1:0]         scale_mag;
   logic [GROUP_W-1:0]         scale_n;
   logic                       scale_single;
   logic                       scale_avg;

   // averaging
   logic signed [SUM_W-1:0]    sum_new;
   logic [GROUP_W-1:0]         grp_new;

   // gain stage
   logic signed [SAMPLE_W:0]   diff;
   logic [COORD_BITS-1:0]      top;
   logic [PROD_W-17:0]         q_hi;

   // column emission
   logic                       out_free;
   logic [MODE_W-1:0]          kind;
   logic [XPOS_W-1:0]          x_col;
   logic [XPOS_W-1:0]          x_pos;
   logic [COORD_BITS-1:0]      y_to;
   logic [COORD_BITS-1:0]      y_from;
   logic                       sticky_new;
   logic [XPOS_W-1:0]          col_next;
   logic                       col_fits;
   logic                       col_final;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);

   assign scale_mag    = x_scale_ff[SCALE_W-1] ? SCALE_W'(-x_scale_ff) : SCALE_W'(x_scale_ff);
   assign scale_n      = (scale_mag > SCALE_W'(MAX_SCALE)) ? GROUP_W'(MAX_SCALE)
                                                           : scale_mag[GROUP_W-1:0];
   assign scale_single = (x_scale_ff == SCALE_W'(0)) || (x_scale_ff == SCALE_W'(1));
   assign scale_avg    = x_scale_ff[SCALE_W-1];

   assign sum_new = sum_ff + SUM_W'(smp_ff);
   assign grp_new = grp_ff + 1'b1;

   // divider request: only when an averaging group closes
   assign div_req.start    = (state_ff == S_DECODE) && scale_avg && (grp_new >= scale_n);
   assign div_req.dividend = sum_new;
   assign div_req.divisor  = grp_new;

   stcm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign diff = (SAMPLE_W+1)'(val_ff) - (SAMPLE_W+1)'(y_offset_ff);
   assign top  = (plot_height_ff == '0) ? '0 : plot_height_ff - 1'b1;
   assign q_hi = prod_ff[PROD_W-1:16];

   // column payload
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign kind       = (first_ff || draw_mode_ff == KIND_UNUSED) ? KIND_PIXEL : draw_mode_ff;
   assign x_col      = XPOS_W'(base_x_ff) + col_ff;
   assign x_pos      = (kind == KIND_LINE) ? x_col - 1'b1 : x_col;
   assign y_to       = screen_y(base_y_ff, h_ff);
   assign sticky_new = sticky_ff | hclip_ff;
   assign col_next   = col_ff + 1'b1;
   assign col_fits   = col_ff < XPOS_W'(plot_width_ff);
   assign col_final  = (rep_ff == GROUP_W'(1)) || (col_next >= XPOS_W'(plot_width_ff));

   always_comb begin
      unique case (kind)
         KIND_LINE: y_from = screen_y(base_y_ff, prev_ff);
         KIND_AREA: y_from = base_y_ff;
         default:   y_from = y_to;
      endcase
   end

   always_comb begin
      x_scale_in     = x_scale_ff;
      y_gain_in      = y_gain_ff;
      y_offset_in    = y_offset_ff;
      plot_width_in  = plot_width_ff;
      plot_height_in = plot_height_ff;
      base_x_in      = base_x_ff;
      base_y_in      = base_y_ff;
      draw_mode_in   = draw_mode_ff;

      col_in    = col_ff;
      sum_in    = sum_ff;
      grp_in    = grp_ff;
      prev_in   = prev_ff;
      first_in  = first_ff;
      sticky_in = sticky_ff;

      state_in  = state_ff;
      smp_in    = smp_ff;
      last_in   = last_ff;
      val_in    = val_ff;
      rep_in    = rep_ff;
      prod_in   = prod_ff;
      h_in      = h_ff;
      hclip_in  = hclip_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_X_SCALE:     x_scale_in     = csr_data[SCALE_W-1:0];
            REG_Y_GAIN:      y_gain_in      = csr_data[GAIN_W-1:0];
            REG_Y_OFFSET:    y_offset_in    = csr_data[SAMPLE_W-1:0];
            REG_PLOT_WIDTH:  plot_width_in  = csr_data[COORD_BITS-1:0];
            REG_PLOT_HEIGHT: plot_height_in = csr_data[COORD_BITS-1:0];
            REG_BASE_X:      base_x_in      = csr_data[COORD_BITS-1:0];
            REG_BASE_Y:      base_y_in      = csr_data[COORD_BITS-1:0];
            REG_DRAW_MODE:   draw_mode_in   = csr_data[MODE_W-1:0];
            default:         ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               smp_in   = req_tdata;
               last_in  = req_tlast;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (scale_single) begin
               val_in   = smp_ff;
               rep_in   = GROUP_W'(1);
               state_in = S_MUL;
            end else if (scale_avg) begin
               if (div_req.start) begin
                  sum_in   = '0;
                  grp_in   = '0;
                  rep_in   = GROUP_W'(1);
                  state_in = S_DIV;
               end else begin
                  sum_in   = sum_new;
                  grp_in   = grp_new;
                  state_in = S_FINISH;
               end
            end else begin
               val_in   = smp_ff;
               rep_in   = scale_n;
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               val_in   = div_rsp.quotient[SAMPLE_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // unsigned gain times signed difference, both sign-extended to the product width
            prod_in  = $signed({1'b0, y_gain_ff}) * diff;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            // truncate toward zero, then clip to 0 .. top
            if (prod_ff[PROD_W-1]) begin
               h_in     = '0;
               hclip_in = !((&q_hi) && (|prod_ff[15:0]));
            end else if (q_hi > (PROD_W-16)'(top)) begin
               h_in     = top;
               hclip_in = 1'b1;
            end else begin
               h_in     = q_hi[COORD_BITS-1:0];
               hclip_in = 1'b0;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!col_fits) begin
               state_in = S_FINISH;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, sticky_new, hclip_ff, y_to, y_from, x_pos};
               rsp_kind_in  = kind;
               rsp_last_in  = col_final;
               sticky_in    = sticky_new;
               first_in     = 1'b0;
               prev_in      = h_ff;
               col_in       = col_next;
               rep_in       = rep_ff - 1'b1;
               if (col_final) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (last_ff) begin
               col_in    = '0;
               sum_in    = '0;
               grp_in    = '0;
               prev_in   = '0;
               first_in  = 1'b1;
               sticky_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff     <= SCALE_W'(1);
         y_gain_ff      <= GAIN_W'(65536);
         y_offset_ff    <= '0;
         plot_width_ff  <= COORD_BITS'(320);
         plot_height_ff <= COORD_BITS'(240);
         base_x_ff      <= '0;
         base_y_ff      <= COORD_BITS'(239);
         draw_mode_ff   <= KIND_PIXEL;
         col_ff         <= '0;
         sum_ff         <= '0;
         grp_ff         <= '0;
         prev_ff        <= '0;
         first_ff       <= 1'b1;
         sticky_ff      <= 1'b0;
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         x_scale_ff     <= x_scale_in;
         y_gain_ff      <= y_gain_in;
         y_offset_ff    <= y_offset_in;
         plot_width_ff  <= plot_width_in;
         plot_height_ff <= plot_height_in;
         base_x_ff      <= base_x_in;
         base_y_ff      <= base_y_in;
         draw_mode_ff   <= draw_mode_in;
         col_ff         <= col_in;
         sum_ff         <= sum_in;
         grp_ff         <= grp_in;
         prev_ff        <= prev_in;
         first_ff       <= first_in;
         sticky_ff      <= sticky_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      last_ff     <= last_in;
      val_ff      <= val_in;
      rep_ff      <= rep_in;
      prod_ff     <= prod_in;
      h_ff        <= h_in;
      hclip_ff    <= hclip_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
